// ----- hw/rtl/rkac_pkg.sv -----
// Package with shared types, codes and key normalization for the RFID key table block.
package rkac_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ID_BYTES        = 7;
  localparam int ID_W            = 56;
  localparam int LEN_W           = 3;
  localparam int STATUS_W        = 4;
  localparam int IDX_OUT_W       = 4;
  localparam int CNT_OUT_W       = 5;
  localparam int CFG_IDX_W       = 2;

  localparam logic [LEN_W-1:0] RESET_KEY_LEN = LEN_W'(4);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
  } key_t;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_ADD     = 2'd1,
    REQ_DEL     = 2'd2,
    REQ_RESTORE = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED    = 4'd0,
    ST_DENIED     = 4'd1,
    ST_MODE       = 4'd2,
    ST_MASTER_OK  = 4'd3,
    ST_MASTER_BAD = 4'd4,
    ST_ADDED      = 4'd5,
    ST_PRESENT    = 4'd6,
    ST_DELETED    = 4'd7,
    ST_NOT_FOUND  = 4'd8,
    ST_PROTECTED  = 4'd9,
    ST_FULL       = 4'd10,
    ST_RESTORED   = 4'd11
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASTER_KEY  = 2'd0,
    CFG_MASTER_LEN  = 2'd1,
    CFG_DEFAULT_KEY = 2'd2,
    CFG_DEFAULT_LEN = 2'd3
  } cfg_idx_t;

  // Limits the byte count and clears all bytes above it.
  function automatic key_t norm_key(logic [ID_W-1:0] id, logic [LEN_W-1:0] len);
    key_t             k;
    logic [LEN_W-1:0] n;
    n = (int'(len) > ID_BYTES) ? LEN_W'(ID_BYTES) : len;
    k.len = n;
    for (int b = 0; b < ID_W / 8; b++) begin
      k.id[8*b +: 8] = (b < int'(n)) ? id[8*b +: 8] : 8'h00;
    end
    return k;
  endfunction

endpackage

// ----- hw/rtl/rkac_in_if.sv -----
// Input channel interface carrying one request item.
interface rkac_in_if import rkac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [ID_W-1:0]  uid_value;
  logic [LEN_W-1:0] uid_len;

  modport source (output valid, req_type, uid_value, uid_len, input ready);
  modport sink (input valid, req_type, uid_value, uid_len, output ready);
endinterface

// ----- hw/rtl/rkac_out_if.sv -----
// Result channel interface carrying one status item.
interface rkac_out_if import rkac_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 lock_open;
  logic [IDX_OUT_W-1:0] match_index;
  logic                 add_mode;
  logic                 del_mode;
  logic                 master_ok;
  logic [CNT_OUT_W-1:0] key_count;

  modport source (output valid, status, lock_open, match_index, add_mode, del_mode,
                  master_ok, key_count, input ready);
  modport sink (input valid, status, lock_open, match_index, add_mode, del_mode,
                master_ok, key_count, output ready);
endinterface

// ----- hw/rtl/rkac_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module rkac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/rkac_cmp.sv -----
// Shared key comparator: normalizes the table or master key and matches it against the probe.
module rkac_cmp import rkac_pkg::*; (
  input  key_t probe,
  input  key_t cand,
  output logic match
);

  key_t cand_norm;

  assign cand_norm = norm_key(cand.id, cand.len);
  assign match     = (probe == cand_norm);

endmodule

// ----- hw/rtl/rfid_key_table_access_control.sv -----
// Top level of the RFID key table access control block.
// The block holds a table of authorized card IDs in a RAM and answers every request item
// with one result item. A card read checks the master card and then scans the table one
// entry per cycle through the RAM read port and the single key comparator. It then decides
// in the decide state and registers its result in the finish state; no new item is accepted
// until that result has gone into the output register. A delete then moves every later entry
// down by one, reading each moved entry in the delete state and writing it in the move state.
// Mode toggles and restore go straight to the finish state. After reset the block writes
// the initial key in its init state before it takes its first item.
module rfid_key_table_access_control import rkac_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rkac_in_if.sink              in_ch,
  rkac_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]      cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_MASTER, S_SCAN, S_DECIDE, S_DEL, S_MOVE, S_FINISH
  } state_t;

  logic [ID_W-1:0]  master_key_r, default_key_r;
  logic [LEN_W-1:0] master_len_r, default_len_r;

  state_t               state_r, state_nxt;
  key_t                 probe_r, probe_nxt;
  logic                 is_master_r, is_master_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 cmp_pend_r, cmp_pend_nxt;
  logic [AW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                 hit_vld_r, hit_vld_nxt;
  logic [AW-1:0]        hit_idx_r, hit_idx_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 lock_r, lock_nxt;
  logic                 adding_r, adding_nxt;
  logic                 deleting_r, deleting_nxt;
  logic                 seen_r, seen_nxt;
  logic [AW-1:0]        last_match_r, last_match_nxt;
  status_t              status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic                 out_lock_r, out_lock_nxt;
  logic [IDX_OUT_W-1:0] out_match_r, out_match_nxt;
  logic                 out_add_r, out_add_nxt;
  logic                 out_del_r, out_del_nxt;
  logic                 out_seen_r, out_seen_nxt;
  logic [CNT_OUT_W-1:0] out_count_r, out_count_nxt;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  key_t          ram_wr_data;
  logic [AW-1:0] ram_rd_addr;
  key_t          ram_rd_data;
  key_t          cmp_cand;
  logic          cmp_match;
  logic [CW-1:0] idx_inc;
  logic          scan_issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_key_r  <= '0;
      master_len_r  <= RESET_KEY_LEN;
      default_key_r <= '0;
      default_len_r <= RESET_KEY_LEN;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MASTER_KEY:  master_key_r  <= cfg_wdata;
        CFG_MASTER_LEN:  master_len_r  <= cfg_wdata[LEN_W-1:0];
        CFG_DEFAULT_KEY: default_key_r <= cfg_wdata;
        CFG_DEFAULT_LEN: default_len_r <= cfg_wdata[LEN_W-1:0];
      endcase
    end
  end

  rkac_ram #(
    .WIDTH ($bits(key_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign cmp_cand = (state_r == S_MASTER) ? key_t'{master_key_r, master_len_r} : ram_rd_data;

  rkac_cmp u_cmp (
    .probe (probe_r),
    .cand  (cmp_cand),
    .match (cmp_match)
  );

  assign idx_inc    = idx_r + CW'(1);
  assign scan_issue = (idx_r < count_r);

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.lock_open   = out_lock_r;
  assign out_ch.match_index = out_match_r;
  assign out_ch.add_mode    = out_add_r;
  assign out_ch.del_mode    = out_del_r;
  assign out_ch.master_ok   = out_seen_r;
  assign out_ch.key_count   = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    probe_nxt      = probe_r;
    is_master_nxt  = is_master_r;
    idx_nxt        = idx_r;
    cmp_pend_nxt   = cmp_pend_r;
    cmp_idx_nxt    = cmp_idx_r;
    hit_vld_nxt    = hit_vld_r;
    hit_idx_nxt    = hit_idx_r;
    count_nxt      = count_r;
    lock_nxt       = lock_r;
    adding_nxt     = adding_r;
    deleting_nxt   = deleting_r;
    seen_nxt       = seen_r;
    last_match_nxt = last_match_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_lock_nxt   = out_lock_r;
    out_match_nxt  = out_match_r;
    out_add_nxt    = out_add_r;
    out_del_nxt    = out_del_r;
    out_seen_nxt   = out_seen_r;
    out_count_nxt  = out_count_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = idx_r[AW-1:0];
    ram_wr_data    = ram_rd_data;
    ram_rd_addr    = idx_r[AW-1:0];

    unique case (state_r)
      S_INIT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = '0;
        ram_wr_data = norm_key('0, RESET_KEY_LEN);
        state_nxt   = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          probe_nxt    = norm_key(in_ch.uid_value, in_ch.uid_len);
          hit_vld_nxt  = 1'b0;
          cmp_pend_nxt = 1'b0;
          idx_nxt      = '0;
          state_nxt    = S_FINISH;
          unique case (req_t'(in_ch.req_type))
            REQ_READ: begin
              state_nxt = S_MASTER;
            end
            REQ_ADD: begin
              if (deleting_r) begin
                status_nxt = ST_DENIED;
              end else begin
                adding_nxt = !adding_r;
                seen_nxt   = 1'b0;
                status_nxt = ST_MODE;
              end
            end
            REQ_DEL: begin
              if (adding_r) begin
                status_nxt = ST_DENIED;
              end else begin
                deleting_nxt = !deleting_r;
                seen_nxt     = 1'b0;
                status_nxt   = ST_MODE;
              end
            end
            REQ_RESTORE: begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = '0;
              ram_wr_data = norm_key(default_key_r, default_len_r);
              count_nxt   = CW'(1);
              status_nxt  = ST_RESTORED;
            end
          endcase
        end
      end
      S_MASTER: begin
        is_master_nxt = cmp_match;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        if (cmp_pend_r && cmp_match) begin
          hit_vld_nxt = 1'b1;
          hit_idx_nxt = cmp_idx_r;
        end
        cmp_pend_nxt = scan_issue;
        cmp_idx_nxt  = idx_r[AW-1:0];
        if (scan_issue) begin
          idx_nxt = idx_inc;
        end else if (!cmp_pend_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_FINISH;
        if (!adding_r && !deleting_r) begin
          if (hit_vld_r) begin
            lock_nxt       = !lock_r;
            last_match_nxt = hit_idx_r;
            status_nxt     = ST_GRANTED;
          end else begin
            status_nxt = ST_DENIED;
          end
        end else if (!seen_r) begin
          if (is_master_r) begin
            seen_nxt   = 1'b1;
            status_nxt = ST_MASTER_OK;
          end else begin
            status_nxt = ST_MASTER_BAD;
          end
        end else if (adding_r) begin
          if (hit_vld_r) begin
            status_nxt = ST_PRESENT;
          end else if (count_r >= CW'(TABLE_DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = count_r[AW-1:0];
            ram_wr_data = probe_r;
            count_nxt   = count_r + CW'(1);
            adding_nxt  = 1'b0;
            seen_nxt    = 1'b0;
            status_nxt  = ST_ADDED;
          end
        end else begin
          if (!hit_vld_r) begin
            status_nxt = ST_NOT_FOUND;
          end else if (is_master_r) begin
            status_nxt = ST_PROTECTED;
          end else begin
            idx_nxt   = CW'(hit_idx_r);
            state_nxt = S_DEL;
          end
        end
      end
      S_DEL: begin
        if (idx_inc < count_r) begin
          ram_rd_addr = idx_inc[AW-1:0];
          state_nxt   = S_MOVE;
        end else begin
          count_nxt    = count_r - CW'(1);
          deleting_nxt = 1'b0;
          seen_nxt     = 1'b0;
          status_nxt   = ST_DELETED;
          state_nxt    = S_FINISH;
        end
      end
      S_MOVE: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_r[AW-1:0];
        ram_wr_data = ram_rd_data;
        idx_nxt     = idx_inc;
        state_nxt   = S_DEL;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_lock_nxt   = lock_r;
          out_match_nxt  = IDX_OUT_W'(last_match_r);
          out_add_nxt    = adding_r;
          out_del_nxt    = deleting_r;
          out_seen_nxt   = seen_r;
          out_count_nxt  = CNT_OUT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      probe_r      <= '0;
      is_master_r  <= 1'b0;
      idx_r        <= '0;
      cmp_pend_r   <= 1'b0;
      cmp_idx_r    <= '0;
      hit_vld_r    <= 1'b0;
      hit_idx_r    <= '0;
      count_r      <= CW'(1);
      lock_r       <= 1'b0;
      adding_r     <= 1'b0;
      deleting_r   <= 1'b0;
      seen_r       <= 1'b0;
      last_match_r <= '0;
      status_r     <= ST_GRANTED;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_GRANTED;
      out_lock_r   <= 1'b0;
      out_match_r  <= '0;
      out_add_r    <= 1'b0;
      out_del_r    <= 1'b0;
      out_seen_r   <= 1'b0;
      out_count_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      probe_r      <= probe_nxt;
      is_master_r  <= is_master_nxt;
      idx_r        <= idx_nxt;
      cmp_pend_r   <= cmp_pend_nxt;
      cmp_idx_r    <= cmp_idx_nxt;
      hit_vld_r    <= hit_vld_nxt;
      hit_idx_r    <= hit_idx_nxt;
      count_r      <= count_nxt;
      lock_r       <= lock_nxt;
      adding_r     <= adding_nxt;
      deleting_r   <= deleting_nxt;
      seen_r       <= seen_nxt;
      last_match_r <= last_match_nxt;
      status_r     <= status_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_lock_r   <= out_lock_nxt;
      out_match_r  <= out_match_nxt;
      out_add_r    <= out_add_nxt;
      out_del_r    <= out_del_nxt;
      out_seen_r   <= out_seen_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

endmodule

// ----- hw/rtl/rkac_checker.sv -----
// Port-level assertion checker for the RFID key table block and its bind statement.
module rkac_checker import rkac_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [STATUS_W-1:0]  status,
  input logic                 add_mode,
  input logic                 del_mode,
  input logic                 master_ok
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("A stalled result item changed or vanished.");

  a_modes_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(add_mode && del_mode))
    else $error("Add and delete modes are active together.");

  a_normal_no_master: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !add_mode && !del_mode |-> !master_ok)
    else $error("Master acceptance is set outside a mode session.");

  a_added_ends_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_ADDED) |-> !add_mode && !master_ok)
    else $error("Add mode did not end after a key was added.");

endmodule

bind rfid_key_table_access_control rkac_checker u_rkac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .add_mode  (out_ch.add_mode),
  .del_mode  (out_ch.del_mode),
  .master_ok (out_ch.master_ok)
);

// ----- sim/rfid_key_table_access_control_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the card table access controller: random and directed requests.
module rfid_key_table_access_control_test;
  import rkac_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int POOL_SIZE = 24;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [ID_W-1:0] ALL_ONES = {ID_W{1'b1}};

  typedef struct {
    req_t             kind;
    logic [ID_W-1:0]  uid;
    logic [LEN_W-1:0] len;
  } card_req_t;

  typedef struct {
    status_t              status;
    logic                 lock_open;
    logic [IDX_OUT_W-1:0] match_index;
    logic                 add_mode;
    logic                 del_mode;
    logic                 master_ok;
    logic [CNT_OUT_W-1:0] key_count;
  } door_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ID_W-1:0]      cfg_wdata;

  rkac_in_if  in_ch ();
  rkac_out_if out_ch ();

  rfid_key_table_access_control DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state and its copy of the registers.
  logic [ID_W-1:0]      master_id;
  logic [LEN_W-1:0]     master_bytes;
  logic [ID_W-1:0]      default_id;
  logic [LEN_W-1:0]     default_bytes;
  logic [ID_W-1:0]      card_ids [DEPTH];
  logic [LEN_W-1:0]     card_lens [DEPTH];
  int                   card_count;
  logic                 lock_is_open;
  logic                 adding;
  logic                 deleting;
  logic                 master_shown;
  logic [IDX_OUT_W-1:0] last_hit;

  card_req_t        pending_reqs [$];
  door_result_t     expected_results [$];
  logic [ID_W-1:0]  pool_ids [POOL_SIZE];
  logic [LEN_W-1:0] pool_lens [POOL_SIZE];

  int failures = 0;
  int results_seen = 0;
  int cycle_count = 0;
  bit took_req = 0;
  bit took_res = 0;
  int send_gap = 0;
  int send_burst = 0;
  int recv_wait = 0;
  int recv_burst = 0;
  bit long_hold_done = 0;

  function automatic logic [ID_W-1:0] byte_mask(logic [LEN_W-1:0] n);
    if (int'(n) >= ID_BYTES) return ALL_ONES;
    return (ID_W'(1) << (8 * n)) - ID_W'(1);
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'({$urandom, $urandom});
  endfunction

  // Fills the bytes above the count with noise; they must not matter.
  function automatic logic [ID_W-1:0] smudge(logic [ID_W-1:0] v, logic [LEN_W-1:0] n);
    logic [ID_W-1:0] keep;
    keep = byte_mask(n);
    return (v & keep) | (rand_id() & ~keep);
  endfunction

  function automatic void reload_table();
    for (int i = 0; i < DEPTH; i++) begin
      card_ids[i] = '0;
      card_lens[i] = '0;
    end
    card_ids[0] = default_id & byte_mask(default_bytes);
    card_lens[0] = default_bytes;
    card_count = 1;
  endfunction

  function automatic status_t judge_card(logic [ID_W-1:0] raw, logic [LEN_W-1:0] n);
    logic [ID_W-1:0] v;
    bit              is_master;
    int              hit;
    v = raw & byte_mask(n);
    is_master = (n == master_bytes) && (v == (master_id & byte_mask(master_bytes)));
    hit = -1;
    for (int i = 0; i < card_count; i++) begin
      if (card_lens[i] == n && card_ids[i] == v) hit = i;
    end
    if (!adding && !deleting) begin
      if (hit < 0) return ST_DENIED;
      lock_is_open = ~lock_is_open;
      last_hit = IDX_OUT_W'(hit);
      return ST_GRANTED;
    end
    if (!master_shown) begin
      if (!is_master) return ST_MASTER_BAD;
      master_shown = 1'b1;
      return ST_MASTER_OK;
    end
    if (adding) begin
      if (hit >= 0) return ST_PRESENT;
      if (card_count >= DEPTH) return ST_FULL;
      card_ids[card_count] = v;
      card_lens[card_count] = n;
      card_count++;
      adding = 1'b0;
      master_shown = 1'b0;
      return ST_ADDED;
    end
    if (hit < 0) return ST_NOT_FOUND;
    if (is_master) return ST_PROTECTED;
    for (int i = hit; i + 1 < card_count; i++) begin
      card_ids[i] = card_ids[i + 1];
      card_lens[i] = card_lens[i + 1];
    end
    card_count--;
    card_ids[card_count] = '0;
    card_lens[card_count] = '0;
    deleting = 1'b0;
    master_shown = 1'b0;
    return ST_DELETED;
  endfunction

  function automatic door_result_t predict_request(card_req_t r);
    door_result_t res;
    case (r.kind)
      REQ_READ: begin
        res.status = judge_card(r.uid, r.len);
      end
      REQ_ADD: begin
        if (deleting) begin
          res.status = ST_DENIED;
        end else begin
          adding = ~adding;
          master_shown = 1'b0;
          res.status = ST_MODE;
        end
      end
      REQ_DEL: begin
        if (adding) begin
          res.status = ST_DENIED;
        end else begin
          deleting = ~deleting;
          master_shown = 1'b0;
          res.status = ST_MODE;
        end
      end
      default: begin
        reload_table();
        res.status = ST_RESTORED;
      end
    endcase
    res.lock_open = lock_is_open;
    res.match_index = last_hit;
    res.add_mode = adding;
    res.del_mode = deleting;
    res.master_ok = master_shown;
    res.key_count = CNT_OUT_W'(card_count);
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  initial begin
    clk = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_READ;
    in_ch.uid_value = '0;
    in_ch.uid_len = '0;
    out_ch.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Acceptance on both channels; the request side is handled first.
  always @(posedge clk) begin
    card_req_t    r;
    door_result_t want;
    took_req = 1'b0;
    took_res = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        took_req = 1'b1;
        r.kind = req_t'(in_ch.req_type);
        r.uid = in_ch.uid_value;
        r.len = in_ch.uid_len;
        expected_results.push_back(predict_request(r));
      end
      if (out_ch.valid && out_ch.ready) begin
        took_res = 1'b1;
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result item with no request outstanding");
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_ch.status);
          check_field("lock_open", want.lock_open, out_ch.lock_open);
          check_field("match_index", want.match_index, out_ch.match_index);
          check_field("add_mode", want.add_mode, out_ch.add_mode);
          check_field("del_mode", want.del_mode, out_ch.del_mode);
          check_field("master_ok", want.master_ok, out_ch.master_ok);
          check_field("key_count", want.key_count, out_ch.key_count);
        end
      end
    end
  end

  // Request driver.
  always @(negedge clk) begin
    card_req_t r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || took_req) begin
      if (took_req) begin
        if (send_burst > 0) begin
          send_burst--;
          send_gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          send_burst = 20;
          send_gap = 0;
        end else begin
          send_gap = $urandom_range(0, 12);
        end
      end
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_ch.req_type <= r.kind;
        in_ch.uid_value <= r.uid;
        in_ch.uid_len <= r.len;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off to back the block up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (took_res) begin
        if (results_seen == 60 && !long_hold_done) begin
          recv_wait = 400;
          long_hold_done = 1'b1;
        end else if (recv_burst > 0) begin
          recv_burst--;
          recv_wait = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          recv_burst = 20;
          recv_wait = 0;
        end else begin
          recv_wait = $urandom_range(0, 12);
        end
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_req(req_t kind, logic [ID_W-1:0] uid, logic [LEN_W-1:0] len);
    card_req_t r;
    r.kind = kind;
    r.uid = uid;
    r.len = len;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_card(logic [ID_W-1:0] v, logic [LEN_W-1:0] n);
    queue_req(REQ_READ, smudge(v, n), n);
  endtask

  task automatic queue_toggle(req_t kind);
    queue_req(kind, rand_id(), LEN_W'($urandom_range(0, 7)));
  endtask

  task automatic queue_master();
    int k;
    k = $urandom_range(1, POOL_SIZE - 1);
    if ($urandom_range(0, 9) == 0) queue_card(pool_ids[k], pool_lens[k]);
    else queue_card(master_id, master_bytes);
  endtask

  task automatic fill_pool();
    pool_ids[0] = master_id;
    pool_lens[0] = master_bytes;
    pool_ids[1] = default_id;
    pool_lens[1] = default_bytes;
    pool_ids[2] = default_id;
    pool_lens[2] = default_bytes + 1'b1;
    for (int i = 3; i < POOL_SIZE; i++) begin
      pool_ids[i] = rand_id();
      pool_lens[i] = LEN_W'($urandom_range(0, 7));
    end
  endtask

  // Mostly complete add and delete sessions, with reads, restores and noise mixed in.
  task automatic run_random(int n_items, int add_pct, int del_pct);
    int made;
    int pick;
    int k;
    made = 0;
    fill_pool();
    while (made < n_items) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, POOL_SIZE - 1);
      if (pick < add_pct) begin
        queue_toggle(REQ_ADD);
        queue_master();
        queue_card(pool_ids[k], pool_lens[k]);
        made += 3;
      end else if (pick < add_pct + del_pct) begin
        queue_toggle(REQ_DEL);
        queue_master();
        queue_card(pool_ids[k], pool_lens[k]);
        made += 3;
      end else if (pick < 92) begin
        queue_card(pool_ids[k], pool_lens[k]);
        made++;
      end else if (pick < 94) begin
        queue_toggle(REQ_RESTORE);
        made++;
      end else begin
        queue_req(req_t'($urandom_range(0, 3)), rand_id(), LEN_W'($urandom_range(0, 7)));
        made++;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_results.size() != 0 || in_ch.valid) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [ID_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_MASTER_KEY:  master_id = value;
      CFG_MASTER_LEN:  master_bytes = value[LEN_W-1:0];
      CFG_DEFAULT_KEY: default_id = value;
      default:         default_bytes = value[LEN_W-1:0];
    endcase
  endtask

  task automatic write_all(logic [ID_W-1:0] mkey, logic [LEN_W-1:0] mlen,
                           logic [ID_W-1:0] dkey, logic [LEN_W-1:0] dlen);
    write_reg(CFG_MASTER_KEY, mkey);
    write_reg(CFG_MASTER_LEN, ID_W'({rand_id(), mlen}));
    write_reg(CFG_DEFAULT_KEY, dkey);
    write_reg(CFG_DEFAULT_LEN, ID_W'({rand_id(), dlen}));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MASTER_KEY;
    cfg_wdata = '0;
    master_id = '0;
    master_bytes = RESET_KEY_LEN;
    default_id = '0;
    default_bytes = RESET_KEY_LEN;
    reload_table();
    lock_is_open = 1'b0;
    adding = 1'b0;
    deleting = 1'b0;
    master_shown = 1'b0;
    last_hit = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // With the reset registers the master card is also the stored default key.
    queue_card('0, 3'd4);
    queue_card('0, 3'd0);
    queue_card(ALL_ONES, 3'd7);
    queue_toggle(REQ_ADD);
    queue_toggle(REQ_DEL);
    queue_card(56'h12345678, 3'd4);
    queue_card('0, 3'd4);
    queue_card('0, 3'd4);
    queue_card(ALL_ONES, 3'd7);
    queue_card(ALL_ONES, 3'd7);
    queue_toggle(REQ_ADD);
    queue_toggle(REQ_ADD);
    queue_toggle(REQ_DEL);
    queue_toggle(REQ_ADD);
    queue_card('0, 3'd4);
    queue_card(56'hAB, 3'd1);
    queue_card('0, 3'd4);
    queue_card(ALL_ONES, 3'd7);
    queue_toggle(REQ_ADD);
    queue_card('0, 3'd4);
    queue_card('0, 3'd0);
    queue_card('0, 3'd0);
    queue_toggle(REQ_DEL);
    queue_toggle(REQ_DEL);
    queue_toggle(REQ_RESTORE);
    run_random(110, 40, 20);
    wait_idle();

    write_all(rand_id(), 3'd7, rand_id(), 3'd3);
    queue_toggle(REQ_RESTORE);
    run_random(110, 55, 10);
    wait_idle();

    write_all(ALL_ONES, 3'd7, '0, 3'd0);
    queue_toggle(REQ_RESTORE);
    run_random(110, 40, 20);
    wait_idle();

    write_all('0, 3'd0, ALL_ONES, 3'd7);
    queue_toggle(REQ_RESTORE);
    run_random(110, 35, 25);
    wait_idle();

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rkac_pkg.sv
hw/rtl/rkac_in_if.sv
hw/rtl/rkac_out_if.sv
hw/rtl/rkac_ram.sv
hw/rtl/rkac_cmp.sv
hw/rtl/rfid_key_table_access_control.sv
hw/rtl/rkac_checker.sv
sim/rfid_key_table_access_control_test.sv
